// ===== hdl/radial_deadzone_stick_scaler_defines.svh =====
// ----------------------------------------------------------------------------
// Radial deadzone stick scaler: assertion macros
// Concurrent assertion helpers, clocked on clk_i. They compile away under
// SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef RADIAL_DEADZONE_STICK_SCALER_DEFINES_SVH
`define RADIAL_DEADZONE_STICK_SCALER_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define RDSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define RDSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RDSS_ASSERT(lbl, prop, msg)
`define RDSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/rdss_pkg.sv =====
// ----------------------------------------------------------------------------
// Radial deadzone stick scaler: package
// Widths, constants, stage types and the step functions of the square root
// and divider pipelines.
// ----------------------------------------------------------------------------
package rdss_pkg;

  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned SENS_W     = 16;
  localparam int unsigned DELTA_W    = 18;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned AXIS_FULL_SCALE = 32768;
  localparam int unsigned DEADZONE_RESET  = 8000;
  localparam int unsigned SENS_RESET      = 3840;
  localparam int          DELTA_LIMIT     = 92682;

  // magnitude and square root
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned REM_W    = MAG_W + 3;
  localparam int unsigned ISQ_STEPS_PER_STAGE = 4;
  localparam int unsigned ISQ_STAGES = MAG_W / ISQ_STEPS_PER_STAGE;

  // scaling and division
  localparam int unsigned SPAN_W = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned NUM_W  = PROD_W + SENS_W;
  localparam int unsigned QUO_W  = 17;
  localparam int unsigned DEN_W  = NUM_W - QUO_W;
  localparam int unsigned DREM_W = DEN_W + 1;
  localparam int unsigned DIV_STEPS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES =
    (QUO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

  localparam logic [QUO_W-1:0] DELTA_MAX_Q = QUO_W'(DELTA_LIMIT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE    = 1'b0,
    REG_SENSITIVITY = 1'b1
  } rdss_reg_e;

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [AXIS_W-1:0] abs_x;
    logic [AXIS_W-1:0] abs_y;
  } rdss_axes_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic moved;
  } rdss_sign_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] root;
    logic [SQ_W-1:0]  rad;
  } rdss_isq_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
  } rdss_div_t;

  typedef struct packed {
    rdss_div_t        x;
    rdss_div_t        y;
    logic             ovf_x;
    logic             ovf_y;
    logic [DEN_W-1:0] den;
    rdss_sign_t       sgn;
  } rdss_dstage_t;

  // one result bit of the digit-by-digit square root
  function automatic rdss_isq_t isq_step(rdss_isq_t s);
    rdss_isq_t        n;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] t;
    r2    = {s.rem[REM_W-3:0], s.rad[SQ_W-1 -: 2]};
    t     = {{(REM_W-MAG_W-2){1'b0}}, s.root, 2'b01};
    n.rad = {s.rad[SQ_W-3:0], 2'b00};
    if (r2 >= t) begin
      n.rem  = r2 - t;
      n.root = {s.root[MAG_W-2:0], 1'b1};
    end else begin
      n.rem  = r2;
      n.root = {s.root[MAG_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of restoring division
  function automatic rdss_div_t div_step(rdss_div_t s, logic [DEN_W-1:0] den);
    rdss_div_t         n;
    logic [DREM_W-1:0] r2;
    r2    = {s.rem[DREM_W-2:0], s.low[QUO_W-1]};
    n.low = {s.low[QUO_W-2:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      n.rem = r2 - {1'b0, den};
      n.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.rem = r2;
      n.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== hdl/radial_deadzone_stick_scaler.sv =====
// ----------------------------------------------------------------------------
// Radial deadzone stick scaler
// Throughput: one item per cycle while out_stall_i is low; squares,
// 16-step square root (4 stages), two multiplies and a 17-step divider
// (7 stages) are all fully pipelined.
// Reset empties the pipeline and loads deadzone 8000 and sensitivity 3840.
// ----------------------------------------------------------------------------
`include "radial_deadzone_stick_scaler_defines.svh"

module radial_deadzone_stick_scaler import rdss_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [AXIS_W-1:0]  stick_x_i,
  input  logic signed [AXIS_W-1:0]  stick_y_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DELTA_W-1:0] delta_x_o,
  output logic signed [DELTA_W-1:0] delta_y_o,
  output logic                      moved_o
);

  localparam logic [SPAN_W:0] FULL_SCALE = (SPAN_W+1)'(AXIS_FULL_SCALE);
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = DELTA_W'(DELTA_LIMIT);

  // configuration
  logic [DZ_W-1:0]   dz_q;
  logic [SENS_W-1:0] sens_q;
  logic [SPAN_W:0]   span_diff;
  logic [SPAN_W-1:0] span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= DZ_W'(DEADZONE_RESET);
      sens_q <= SENS_W'(SENS_RESET);
    end else if (cfg_we_i) begin
      case (rdss_reg_e'(cfg_idx_i))
        REG_DEADZONE:    dz_q   <= cfg_data_i[DZ_W-1:0];
        REG_SENSITIVITY: sens_q <= cfg_data_i[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  assign span_diff = FULL_SCALE - (SPAN_W+1)'(dz_q);
  assign span = ((SPAN_W+1)'(dz_q) >= FULL_SCALE) ? SPAN_W'(1) : span_diff[SPAN_W-1:0];

  // handshake chain
  logic rdy_a, rdy_b, rdy_c0, rdy_c1, rdy_d, rdy_e;
  logic vld_a_q, vld_b_q, vld_c0_q, vld_c1_q, vld_d_q, out_vld_q;
  logic isq_in_ready, isq_vld, div_in_ready, div_vld;

  // stage A: squares and axis magnitudes
  logic signed [SQ_W-1:0] sqx_s, sqy_s;
  logic [SQ_W-1:0]        sqx_a_q, sqy_a_q;
  rdss_axes_t             axes_in, axes_a_q;

  assign sqx_s = SQ_W'(stick_x_i) * SQ_W'(stick_x_i);
  assign sqy_s = SQ_W'(stick_y_i) * SQ_W'(stick_y_i);

  always_comb begin
    axes_in.neg_x = stick_x_i[AXIS_W-1];
    axes_in.neg_y = stick_y_i[AXIS_W-1];
    // -(-32768) wraps to 0x8000, read back unsigned as 32768
    axes_in.abs_x = stick_x_i[AXIS_W-1] ? AXIS_W'(-stick_x_i) : AXIS_W'(stick_x_i);
    axes_in.abs_y = stick_y_i[AXIS_W-1] ? AXIS_W'(-stick_y_i) : AXIS_W'(stick_y_i);
  end

  // stage B: sum of squares
  logic [SQ_W-1:0] sum_b_q;
  rdss_axes_t      axes_b_q;

  // square root
  logic [MAG_W-1:0] isq_mag;
  rdss_axes_t       isq_axes;

  rdss_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_b_q),
    .in_ready_o  (isq_in_ready),
    .rad_i       (sum_b_q),
    .axes_i      (axes_b_q),
    .out_valid_o (isq_vld),
    .out_ready_i (rdy_c0),
    .mag_o       (isq_mag),
    .axes_o      (isq_axes)
  );

  // stage C0: deadzone test and excess
  logic [MAG_W-1:0] mag_c0_q, exc_c0_q;
  logic             moved_c0_q;
  rdss_axes_t       axes_c0_q;

  // stage C1: axis * excess and span * magnitude
  logic [PROD_W-1:0] px_c1_q, py_c1_q;
  logic [PROD_W-1:0] den_full;
  logic [DEN_W-1:0]  den_c1_q;
  rdss_sign_t        sgn_c1_q;

  assign den_full = PROD_W'(span) * PROD_W'(mag_c0_q);

  // stage D: times sensitivity
  logic [NUM_W-1:0] nx_d_q, ny_d_q;
  logic [DEN_W-1:0] den_d_q;
  rdss_sign_t       sgn_d_q;

  // divider
  logic [QUO_W-1:0] quo_x, quo_y;
  logic             ovf_x, ovf_y;
  rdss_sign_t       div_sgn;

  rdss_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_d_q),
    .in_ready_o  (div_in_ready),
    .num_x_i     (nx_d_q),
    .num_y_i     (ny_d_q),
    .den_i       (den_d_q),
    .sgn_i       (sgn_d_q),
    .out_valid_o (div_vld),
    .out_ready_i (rdy_e),
    .quo_x_o     (quo_x),
    .quo_y_o     (quo_y),
    .ovf_x_o     (ovf_x),
    .ovf_y_o     (ovf_y),
    .sgn_o       (div_sgn)
  );

  // stage E: saturate, sign, output register
  logic [QUO_W-1:0]          qx_sat, qy_sat;
  logic signed [DELTA_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic                      moved_q;

  always_comb begin
    qx_sat = (ovf_x || quo_x > DELTA_MAX_Q) ? DELTA_MAX_Q : quo_x;
    qy_sat = (ovf_y || quo_y > DELTA_MAX_Q) ? DELTA_MAX_Q : quo_y;
    dx_d   = div_sgn.neg_x ? -$signed({1'b0, qx_sat}) : $signed({1'b0, qx_sat});
    dy_d   = div_sgn.neg_y ? -$signed({1'b0, qy_sat}) : $signed({1'b0, qy_sat});
    if (!div_sgn.moved) begin
      dx_d = '0;
      dy_d = '0;
    end
  end

  assign rdy_e  = !out_vld_q || !out_stall_i;
  assign rdy_d  = !vld_d_q   || div_in_ready;
  assign rdy_c1 = !vld_c1_q  || rdy_d;
  assign rdy_c0 = !vld_c0_q  || rdy_c1;
  assign rdy_b  = !vld_b_q   || isq_in_ready;
  assign rdy_a  = !vld_a_q   || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c0_q  <= 1'b0;
      vld_c1_q  <= 1'b0;
      vld_d_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy_a)  vld_a_q   <= in_valid_i;
      if (rdy_b)  vld_b_q   <= vld_a_q;
      if (rdy_c0) vld_c0_q  <= isq_vld;
      if (rdy_c1) vld_c1_q  <= vld_c0_q;
      if (rdy_d)  vld_d_q   <= vld_c1_q;
      if (rdy_e)  out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      sqx_a_q  <= sqx_s;
      sqy_a_q  <= sqy_s;
      axes_a_q <= axes_in;
    end
    if (rdy_b) begin
      sum_b_q  <= sqx_a_q + sqy_a_q;
      axes_b_q <= axes_a_q;
    end
    if (rdy_c0) begin
      mag_c0_q   <= isq_mag;
      moved_c0_q <= isq_mag > MAG_W'(dz_q);
      exc_c0_q   <= isq_mag - MAG_W'(dz_q);
      axes_c0_q  <= isq_axes;
    end
    if (rdy_c1) begin
      // excess only matters when the stick is outside the deadzone
      px_c1_q  <= PROD_W'(axes_c0_q.abs_x) * PROD_W'(exc_c0_q);
      py_c1_q  <= PROD_W'(axes_c0_q.abs_y) * PROD_W'(exc_c0_q);
      den_c1_q <= den_full[DEN_W-1:0];
      sgn_c1_q <= '{neg_x: axes_c0_q.neg_x, neg_y: axes_c0_q.neg_y, moved: moved_c0_q};
    end
    if (rdy_d) begin
      nx_d_q  <= NUM_W'(px_c1_q) * NUM_W'(sens_q);
      ny_d_q  <= NUM_W'(py_c1_q) * NUM_W'(sens_q);
      den_d_q <= den_c1_q;
      sgn_d_q <= sgn_c1_q;
    end
    if (rdy_e) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      moved_q <= div_sgn.moved;
    end
  end

  assign in_stall_o  = !rdy_a;
  assign out_valid_o = out_vld_q;
  assign delta_x_o   = dx_q;
  assign delta_y_o   = dy_q;
  assign moved_o     = moved_q;

  `RDSS_ASSERT(a_still_zero, out_valid_o && !moved_o |-> delta_x_o == '0 && delta_y_o == '0, "motion inside deadzone")
  `RDSS_ASSERT(a_delta_range, out_valid_o |-> delta_x_o <= DELTA_MAX && delta_x_o >= -DELTA_MAX && delta_y_o <= DELTA_MAX && delta_y_o >= -DELTA_MAX, "delta beyond limit")
  `RDSS_ASSERT(a_front_free, !vld_a_q |-> !in_stall_o, "stall with empty front stage")
  `RDSS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

// ===== hdl/rdss_isqrt.sv =====
// ----------------------------------------------------------------------------
// Radial deadzone stick scaler: integer square root
// Pipelined floor square root of a 32-bit radicand, four result bits per
// stage, with the axis data riding along.
// ----------------------------------------------------------------------------
module rdss_isqrt import rdss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SQ_W-1:0]  rad_i,
  input  rdss_axes_t       axes_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [MAG_W-1:0] mag_o,
  output rdss_axes_t       axes_o
);

  logic       vld_q  [ISQ_STAGES];
  rdss_isq_t  st_q   [ISQ_STAGES];
  rdss_axes_t axes_q [ISQ_STAGES];
  rdss_isq_t  st_d   [ISQ_STAGES];

  logic       vin    [ISQ_STAGES+1];
  logic       rdy    [ISQ_STAGES+1];
  rdss_isq_t  sin    [ISQ_STAGES];
  rdss_axes_t ain    [ISQ_STAGES];

  assign vin[0]          = in_valid_i;
  assign sin[0]          = '{rem: '0, root: '0, rad: rad_i};
  assign ain[0]          = axes_i;
  assign rdy[ISQ_STAGES] = out_ready_i;

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
    rdss_isq_t tmp;

    if (k > 0) begin : g_link
      assign sin[k] = st_q[k-1];
      assign ain[k] = axes_q[k-1];
    end
    assign vin[k+1] = vld_q[k];
    assign rdy[k]   = !vld_q[k] || rdy[k+1];

    always_comb begin
      tmp = sin[k];
      for (int j = 0; j < ISQ_STEPS_PER_STAGE; j++) begin
        tmp = isq_step(tmp);
      end
      st_d[k] = tmp;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        st_q[k]   <= st_d[k];
        axes_q[k] <= ain[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[ISQ_STAGES-1];
  assign mag_o       = st_q[ISQ_STAGES-1].root;
  assign axes_o      = axes_q[ISQ_STAGES-1];

endmodule

// ===== hdl/rdss_divider.sv =====
// ----------------------------------------------------------------------------
// Radial deadzone stick scaler: two-lane divider
// Pipelined restoring division of two numerators by a shared divisor.
// Quotients that would not fit 17 bits are flagged as overflow up front.
// ----------------------------------------------------------------------------
module rdss_divider import rdss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NUM_W-1:0] num_x_i,
  input  logic [NUM_W-1:0] num_y_i,
  input  logic [DEN_W-1:0] den_i,
  input  rdss_sign_t       sgn_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [QUO_W-1:0] quo_x_o,
  output logic [QUO_W-1:0] quo_y_o,
  output logic             ovf_x_o,
  output logic             ovf_y_o,
  output rdss_sign_t       sgn_o
);

  localparam int unsigned NST = DIV_STAGES + 1;

  logic         vld_q [NST];
  rdss_dstage_t st_q  [NST];
  rdss_dstage_t st_d  [NST];
  logic         vin   [NST+1];
  logic         rdy   [NST+1];

  assign vin[0]   = in_valid_i;
  assign rdy[NST] = out_ready_i;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    assign vin[k+1] = vld_q[k];
    assign rdy[k]   = !vld_q[k] || rdy[k+1];

    if (k == 0) begin : g_load
      // quotient >= 2^17 exactly when the upper numerator bits reach the divisor
      always_comb begin
        st_d[k].ovf_x = num_x_i[NUM_W-1:QUO_W] >= den_i;
        st_d[k].ovf_y = num_y_i[NUM_W-1:QUO_W] >= den_i;
        st_d[k].x     = '{rem: {1'b0, num_x_i[NUM_W-1:QUO_W]},
                          low: num_x_i[QUO_W-1:0], quo: '0};
        st_d[k].y     = '{rem: {1'b0, num_y_i[NUM_W-1:QUO_W]},
                          low: num_y_i[QUO_W-1:0], quo: '0};
        st_d[k].den   = den_i;
        st_d[k].sgn   = sgn_i;
      end
    end else begin : g_iter
      localparam int unsigned BASE = (k - 1) * DIV_STEPS_PER_STAGE;
      rdss_dstage_t tmp;

      always_comb begin
        tmp = st_q[k-1];
        for (int unsigned j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
          if (BASE + j < QUO_W) begin
            tmp.x = div_step(tmp.x, tmp.den);
            tmp.y = div_step(tmp.y, tmp.den);
          end
        end
        st_d[k] = tmp;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NST-1];
  assign quo_x_o     = st_q[NST-1].x.quo;
  assign quo_y_o     = st_q[NST-1].y.quo;
  assign ovf_x_o     = st_q[NST-1].ovf_x;
  assign ovf_y_o     = st_q[NST-1].ovf_y;
  assign sgn_o       = st_q[NST-1].sgn;

endmodule
